// File: rtl/core/dq_pkg.sv
// dq_pkg: shared types and codes for the double-ended queue
// operation and status codes, fixed field widths, result bundle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

	localparam int OP_W        = 2;
	localparam int ST_W        = 2;
	localparam int VAL_W       = 32;
	localparam int OCC_W       = 5;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;
	localparam int IN_TUSER_W  = 8;
	localparam int OUT_TUSER_W = 8;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
	localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd2;
	localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic             take;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/dq_ctrl.sv
// dq_ctrl: front index and element count of the ring, store addressing
// and the status of each operation
// depends on dq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dq_ctrl #(
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     fire,
	input  wire logic [dq_pkg::OP_W-1:0]  op,
	output logic                          mem_we,
	output logic                          mem_re,
	output logic [$clog2(DEPTH)-1:0]      mem_addr,
	output dq_pkg::result_t               res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [SW-1:0] rear_sum, last_sum;
	logic [AW-1:0] rear_pos, last_pos, front_dec, front_inc;
	logic          we_raw, re_raw;

	always_comb begin
		rear_sum  = SW'(front_q) + SW'(count_q);
		last_sum  = rear_sum - SW'(1);
		rear_pos  = (rear_sum >= DEPTH_S) ? AW'(rear_sum - DEPTH_S) : AW'(rear_sum);
		last_pos  = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);
		front_dec = (front_q == '0) ? LAST_A : front_q - AW'(1);
		front_inc = (front_q == LAST_A) ? '0 : front_q + AW'(1);
	end

	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		we_raw     = 1'b0;
		re_raw     = 1'b0;
		mem_addr   = front_q;
		res.status = dq_pkg::ST_DONE;
		res.take   = 1'b0;
		unique case (op)
			dq_pkg::OP_PUSH_FRONT: begin
				if (count_q == DEPTH_C) begin
					res.status = dq_pkg::ST_FULL;
				end else begin
					front_d  = front_dec;
					mem_addr = front_dec;
					we_raw   = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			dq_pkg::OP_PUSH_REAR: begin
				if (count_q == DEPTH_C) begin
					res.status = dq_pkg::ST_FULL;
				end else begin
					mem_addr = rear_pos;
					we_raw   = 1'b1;
					count_d  = count_q + CW'(1);
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (count_q == '0) begin
					res.status = dq_pkg::ST_EMPTY;
				end else begin
					mem_addr = front_q;
					front_d  = front_inc;
					re_raw   = 1'b1;
					res.take = 1'b1;
					count_d  = count_q - CW'(1);
				end
			end
			dq_pkg::OP_POP_REAR: begin
				if (count_q == '0) begin
					res.status = dq_pkg::ST_EMPTY;
				end else begin
					mem_addr = last_pos;
					re_raw   = 1'b1;
					res.take = 1'b1;
					count_d  = count_q - CW'(1);
				end
			end
		endcase
		res.occupancy = dq_pkg::OCC_W'(count_d);
	end

	assign mem_we = fire & we_raw;
	assign mem_re = fire & re_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (fire) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dq_store.sv
// dq_store: single-port element ring store, registered read data
// one access per cycle, read data valid the cycle after the read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dq_store #(
	parameter int DEPTH        = 16,
	parameter int ELEMENT_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic                      re,
	input  wire logic [$clog2(DEPTH)-1:0]  addr,
	input  wire logic [ELEMENT_BITS-1:0]   wdata,
	output logic [ELEMENT_BITS-1:0]        rdata
);

	logic [ELEMENT_BITS-1:0] mem_q [DEPTH];
	logic [ELEMENT_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/double_ended_queue.sv
// double_ended_queue: bounded deque over a ring store
// result: presented in the cycle after the operation beat is taken
// throughput: one operation per cycle while the output is not stalled; one single-port store access each
// reset: front index and count cleared (deque empty); store contents undefined,
// no clearing pass, the deque is usable in the first cycle after reset
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH        = 16,
	parameter int ELEMENT_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [dq_pkg::IN_TDATA_W-1:0]      s_tdata,  // item_value[31:0]
	input  wire logic [dq_pkg::IN_TUSER_W-1:0]      s_tuser,  // operation[1:0], zero pad
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [dq_pkg::OUT_TDATA_W-1:0]          m_tdata,  // removed_value[31:0], occupancy[36:32], zero pad
	output logic [dq_pkg::OUT_TUSER_W-1:0]          m_tuser   // status[1:0], zero pad
);

	localparam int AW = $clog2(DEPTH);

	logic                    fire;
	logic                    mem_we, mem_re;
	logic [AW-1:0]           mem_addr;
	logic [ELEMENT_BITS-1:0] wdata, rdata;
	dq_pkg::result_t         res;
	dq_pkg::result_t         res_q;
	logic                    vld_q;
	logic [dq_pkg::VAL_W-1:0] removed;

	assign s_tready = !vld_q || m_tready;
	assign fire     = s_tvalid && s_tready;
	assign wdata    = ELEMENT_BITS'(s_tdata[dq_pkg::VAL_W-1:0]);

	dq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.op       (s_tuser[dq_pkg::OP_W-1:0]),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.res      (res)
	);

	dq_store #(
		.DEPTH        (DEPTH),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (fire) begin
			vld_q <= 1'b1;
		end else if (m_tready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	// store read data lands together with the registered result
	assign removed  = res_q.take ? dq_pkg::VAL_W'(rdata) : '0;
	assign m_tvalid = vld_q;
	assign m_tdata  = {{(dq_pkg::OUT_TDATA_W - dq_pkg::VAL_W - dq_pkg::OCC_W){1'b0}},
		res_q.occupancy, removed};
	assign m_tuser  = {{(dq_pkg::OUT_TUSER_W - dq_pkg::ST_W){1'b0}}, res_q.status};

endmodule

`default_nettype wire

// File: rtl/core/dq_checker.sv
// dq_checker: port-level checks for the double-ended queue, bound to the top level
// depends on dq_pkg and double_ended_queue
`timescale 1ns / 1ps
`default_nettype none

module dq_checker #(
	parameter int DEPTH = 16
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [dq_pkg::OUT_TDATA_W-1:0]    m_tdata,
	input wire logic [dq_pkg::OUT_TUSER_W-1:0]    m_tuser
);

	localparam int VW = dq_pkg::VAL_W;
	localparam int OW = dq_pkg::OCC_W;

	// a result waiting on the master side holds still
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// every taken beat gives a result on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no result");

	// an empty output side never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with no result pending");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[dq_pkg::ST_W-1:0] == dq_pkg::ST_EMPTY
		|-> m_tdata[VW-1:0] == '0 && m_tdata[VW+OW-1:VW] == '0)
		else $error("empty status with data or nonzero occupancy");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[dq_pkg::ST_W-1:0] == dq_pkg::ST_FULL
		|-> m_tdata[VW-1:0] == '0 && m_tdata[VW+OW-1:VW] == OW'(DEPTH))
		else $error("full status with data or wrong occupancy");

endmodule

bind double_ended_queue dq_checker #(
	.DEPTH (DEPTH)
) u_dq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
